### rtl/ebp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebp_pkg
// shared types, constants and helpers for the ebml element header parser
// ----------------------------------------------------------------------------
package ebp_pkg;

    // container stack depth
    localparam int MAX_DEPTH   = 4;
    localparam int STACK_CNT_W = $clog2(MAX_DEPTH + 1);

    // configuration register indexes
    localparam logic [1:0] CFG_START_OFFSET = 2'd0;
    localparam logic [1:0] CFG_TOP_END      = 2'd1;
    localparam logic [1:0] CFG_CONT_ID_A    = 2'd2;
    localparam logic [1:0] CFG_CONT_ID_B    = 2'd3;

    // configuration reset values
    localparam logic [31:0] RST_START_OFFSET = 32'd5;
    localparam logic [31:0] RST_TOP_END      = 32'hffff_ffff;
    localparam logic [27:0] RST_CONT_ID_A    = 28'h853_8067;
    localparam logic [27:0] RST_CONT_ID_B    = 28'hf43_b675;

    // parser phases
    localparam logic [2:0] PH_PRE      = 3'd0;
    localparam logic [2:0] PH_HDR      = 3'd1;
    localparam logic [2:0] PH_ID_MORE  = 3'd2;
    localparam logic [2:0] PH_SZ_FIRST = 3'd3;
    localparam logic [2:0] PH_SZ_MORE  = 3'd4;
    localparam logic [2:0] PH_SKIP     = 3'd5;
    localparam logic [2:0] PH_DONE     = 3'd6;

    typedef struct packed {
        logic [31:0] start_offset;
        logic [31:0] top_end;
        logic [27:0] cont_id_a;
        logic [27:0] cont_id_b;
    } t_cfg;

    typedef struct packed {
        logic        hdr_pop;
        logic        push;
        logic [63:0] push_end;
    } t_stack_cmd;

    typedef struct packed {
        logic       empty_after_pop;
        logic       full;
        logic [2:0] depth;
    } t_stack_stat;

    typedef struct packed {
        logic [63:0] element_id;
        logic [63:0] element_size;
        logic [63:0] element_start;
        logic [63:0] payload_start;
        logic [2:0]  nesting_depth;
        logic        is_container;
        logic        depth_overflow;
    } t_result;

    // zero bits above the length marker, 8 for a zero byte
    function automatic logic [3:0] lead_zeros(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd8;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                n = 4'(7 - i);
            end
        end
        return n;
    endfunction

    // value bits of the first vint byte below the marker
    function automatic logic [7:0] first_bits(input logic [7:0] b, input logic [3:0] n);
        return b & (8'h7f >> n);
    endfunction

endpackage
`default_nettype wire

### rtl/ebml_element_header_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebml_element_header_parser
// byte-stream walker for ebml / matroska files producing one header item
// per element
// ----------------------------------------------------------------------------
// The block takes the file one byte per item, counting stream offsets from
// zero, and gives one result item per element once its size vint is
// complete: stripped id, size, offset of the first id byte, offset of the
// first payload byte, nesting depth and the container / overflow flags.
// Bytes below start_offset are dropped; the two configured container ids are
// descended into, every other payload is skipped by a down counter. Parsing
// ends for good once a top-level header position reaches top_end.
// Throughput is one byte per clock while the result slot is free or being
// emptied. An accepted byte is held in the input register, decoded in a
// single pass against the parser state and the container stack, and any
// result is captured in the output register. The pace is set by that single
// decode pass, whose longest path is the 64 bit end-offset add feeding the
// stack and the parallel end compares on the four stack entries. There is
// no clearing pass after reset.
// Configuration is written through its own channel, always ready, and is
// only to be changed while the parser is idle.
// ----------------------------------------------------------------------------
module ebml_element_header_parser import ebp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    // header result channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [63:0]      o_element_id,
    output logic [63:0]      o_element_size,
    output logic [63:0]      o_element_start,
    output logic [63:0]      o_payload_start,
    output logic [2:0]       o_nesting_depth,
    output logic             o_is_container,
    output logic             o_depth_overflow,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cfg        cfg;
    t_stack_cmd  stack_cmd;
    t_stack_stat stack_stat;
    t_result     result;
    logic [63:0] pos;
    logic        emit;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        advance;
    logic        r_out_valid;
    t_result     r_out;

    // a byte is decoded once the result slot is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_cfg_ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
        end
    end

    ebp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    ebp_parse_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .i_stack     (stack_stat),
        .o_pos       (pos),
        .o_stack_cmd (stack_cmd),
        .o_emit      (emit),
        .o_result    (result)
    );

    ebp_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pos   (pos),
        .i_cmd   (stack_cmd),
        .o_stat  (stack_stat)
    );

    // result register, holds until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_element_id     = r_out.element_id;
    assign o_element_size   = r_out.element_size;
    assign o_element_start  = r_out.element_start;
    assign o_payload_start  = r_out.payload_start;
    assign o_nesting_depth  = r_out.nesting_depth;
    assign o_is_container   = r_out.is_container;
    assign o_depth_overflow = r_out.depth_overflow;

endmodule
`default_nettype wire

### rtl/ebp_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebp_cfg_regs
// configuration register bank, written through its own valid/ready channel
// ----------------------------------------------------------------------------
module ebp_cfg_regs import ebp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_offset <= RST_START_OFFSET;
            r_cfg.top_end      <= RST_TOP_END;
            r_cfg.cont_id_a    <= RST_CONT_ID_A;
            r_cfg.cont_id_b    <= RST_CONT_ID_B;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_OFFSET: r_cfg.start_offset <= i_cfg_data;
                CFG_TOP_END:      r_cfg.top_end      <= i_cfg_data;
                CFG_CONT_ID_A:    r_cfg.cont_id_a    <= i_cfg_data[27:0];
                CFG_CONT_ID_B:    r_cfg.cont_id_b    <= i_cfg_data[27:0];
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### rtl/ebp_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebp_stack
// container end-offset stack with parallel pop compare at each header start
// ----------------------------------------------------------------------------
module ebp_stack import ebp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [63:0] i_pos,
    input  wire t_stack_cmd  i_cmd,
    output t_stack_stat      o_stat
);

    logic [STACK_CNT_W-1:0] r_count;
    logic [STACK_CNT_W-1:0] n_count;
    logic [STACK_CNT_W-1:0] popped;
    logic [63:0]            r_ends [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]   reached;

    // one compare per entry, entries above the count are never looked at
    always_comb begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            reached[i] = (i_pos >= r_ends[i]);
        end
    end

    // walk down from the top while the end has been reached
    always_comb begin
        popped = r_count;
        for (int i = MAX_DEPTH - 1; i >= 0; i--) begin
            if (popped == STACK_CNT_W'(i + 1) && reached[i]) begin
                popped = STACK_CNT_W'(i);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.hdr_pop) begin
            n_count = popped;
        end else if (i_cmd.push) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (i_cmd.push && r_count == STACK_CNT_W'(i)) begin
                r_ends[i] <= i_cmd.push_end;
            end
        end
    end

    assign o_stat.empty_after_pop = (popped == '0);
    assign o_stat.full            = (r_count >= STACK_CNT_W'(MAX_DEPTH));
    assign o_stat.depth           = 3'(r_count);

endmodule
`default_nettype wire

### rtl/ebp_parse_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebp_parse_fsm
// per-byte header decode: vint id and size, skip counter, result forming
// ----------------------------------------------------------------------------
module ebp_parse_fsm import ebp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_byte,
    input  wire t_cfg        i_cfg,
    input  wire t_stack_stat i_stack,
    output logic [63:0]      o_pos,
    output t_stack_cmd       o_stack_cmd,
    output logic             o_emit,
    output t_result          o_result
);

    logic [2:0]  r_phase, n_phase, ph;
    logic [63:0] r_pos, r_pay;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_accum, n_accum;
    logic [63:0] r_held_id, n_held_id;
    logic [63:0] r_hdr_start, n_hdr_start;
    logic [63:0] r_skip, n_skip;
    logic [3:0]  lz;
    logic [63:0] fb;
    logic [63:0] acc_shift;
    logic        match, over, cont;
    logic        emit;
    logic        hdr_pop, push;

    assign lz        = lead_zeros(i_byte);
    assign fb        = 64'(first_bits(i_byte, lz));
    assign acc_shift = {r_accum[55:0], i_byte};

    assign match = (r_held_id == 64'(i_cfg.cont_id_a)) ||
                   (r_held_id == 64'(i_cfg.cont_id_b));
    assign over  = match && i_stack.full;
    assign cont  = match && !over;

    always_comb begin
        n_phase     = r_phase;
        n_left      = r_left;
        n_accum     = r_accum;
        n_held_id   = r_held_id;
        n_hdr_start = r_hdr_start;
        n_skip      = r_skip;
        emit        = 1'b0;
        hdr_pop     = 1'b0;
        push        = 1'b0;

        ph = r_phase;
        if (r_phase == PH_PRE && r_pos >= 64'(i_cfg.start_offset)) begin
            ph = PH_HDR;
        end

        case (ph)
            PH_PRE: begin
                n_phase = PH_PRE;
            end
            PH_HDR: begin
                hdr_pop = 1'b1;
                if (i_stack.empty_after_pop && r_pos >= 64'(i_cfg.top_end)) begin
                    n_phase = PH_DONE;
                end else begin
                    n_hdr_start = r_pos;
                    n_accum     = fb;
                    n_left      = lz;
                    if (lz == 4'd0) begin
                        n_held_id = fb;
                        n_phase   = PH_SZ_FIRST;
                    end else begin
                        n_phase = PH_ID_MORE;
                    end
                end
            end
            PH_ID_MORE: begin
                n_accum = acc_shift;
                n_left  = r_left - 4'd1;
                if (r_left == 4'd1) begin
                    n_held_id = acc_shift;
                    n_phase   = PH_SZ_FIRST;
                end
            end
            PH_SZ_FIRST, PH_SZ_MORE: begin
                if (ph == PH_SZ_FIRST) begin
                    n_accum = fb;
                    n_left  = lz;
                end else begin
                    n_accum = acc_shift;
                    n_left  = r_left - 4'd1;
                end
                if (n_left != 4'd0) begin
                    n_phase = PH_SZ_MORE;
                end else begin
                    emit = 1'b1;
                    if (cont) begin
                        push    = 1'b1;
                        n_phase = PH_HDR;
                    end else if (n_accum == 64'd0) begin
                        n_phase = PH_HDR;
                    end else begin
                        n_skip  = n_accum;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                n_skip = r_skip - 64'd1;
                if (r_skip == 64'd1) begin
                    n_phase = PH_HDR;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_PRE;
            r_pos       <= 64'd0;
            r_pay       <= 64'd1;
            r_left      <= 4'd0;
            r_accum     <= 64'd0;
            r_held_id   <= 64'd0;
            r_hdr_start <= 64'd0;
            r_skip      <= 64'd0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pos       <= r_pos + 64'd1;
            r_pay       <= r_pay + 64'd1;
            r_left      <= n_left;
            r_accum     <= n_accum;
            r_held_id   <= n_held_id;
            r_hdr_start <= n_hdr_start;
            r_skip      <= n_skip;
        end
    end

    assign o_pos                = r_pos;
    assign o_stack_cmd.hdr_pop  = i_step && hdr_pop;
    assign o_stack_cmd.push     = i_step && push;
    assign o_stack_cmd.push_end = r_pay + n_accum;

    assign o_emit                  = emit;
    assign o_result.element_id     = r_held_id;
    assign o_result.element_size   = n_accum;
    assign o_result.element_start  = r_hdr_start;
    assign o_result.payload_start  = r_pay;
    assign o_result.nesting_depth  = i_stack.depth;
    assign o_result.is_container   = cont;
    assign o_result.depth_overflow = over;

endmodule
`default_nettype wire

### rtl/ebp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ebp_checker
// port-level checks on the header result channel of the parser
// ----------------------------------------------------------------------------
module ebp_checker import ebp_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] o_element_start,
    input wire logic [63:0] o_payload_start,
    input wire logic [2:0]  o_nesting_depth,
    input wire logic        o_is_container,
    input wire logic        o_depth_overflow
);

    // a pending item is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped before taken");

    // an element is either descended into or flagged, never both
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_is_container && o_depth_overflow))
        else $error("container and overflow flags both set");

    // overflow only with a full stack
    a_ovf_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_depth_overflow |-> o_nesting_depth == 3'(MAX_DEPTH))
        else $error("overflow flagged below full depth");

    // a header always takes at least two bytes
    a_hdr_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_payload_start != o_element_start &&
                        o_payload_start != o_element_start + 64'd1)
        else $error("payload start too close to element start");

endmodule

bind ebml_element_header_parser ebp_checker u_ebp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_element_start  (o_element_start),
    .o_payload_start  (o_payload_start),
    .o_nesting_depth  (o_nesting_depth),
    .o_is_container   (o_is_container),
    .o_depth_overflow (o_depth_overflow)
);
`default_nettype wire

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the ebml element header parser
// ----------------------------------------------------------------------------
// Feeds the parser a byte stream and tracks every accepted byte in a parser
// model kept in the bench. Header items from the block are compared field by
// field with the model's queue of pending headers. A few directed cases come
// first, covering the start offset, zero sizes, size wraparound and a child
// running past its parent. Random element trees follow under several register
// settings, mixed with noise and cut-off headers, and the run ends with a
// top_end stop. Both channels idle at random, apart from one long steady
// stretch.
// ----------------------------------------------------------------------------
module tb;
    import ebp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 350;

    typedef logic [7:0] byte_q_t[$];

    // clock, reset and block inputs, all known from time zero
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_byte   = 8'h00;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = CFG_START_OFFSET;
    logic [31:0] cfg_data  = 32'd0;

    // block outputs
    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic [63:0] out_id;
    logic [63:0] out_size;
    logic [63:0] out_start;
    logic [63:0] out_pay;
    logic [2:0]  out_depth;
    logic        out_cont;
    logic        out_over;

    // bench bookkeeping
    int          errors     = 0;
    int          bytes_sent = 0;
    int          stall      = 0;
    logic        steady     = 1'b0;

    // register copies as the parser should see them
    logic [31:0] cfg_start = RST_START_OFFSET;
    logic [31:0] cfg_top   = RST_TOP_END;
    logic [27:0] cfg_ida   = RST_CONT_ID_A;
    logic [27:0] cfg_idb   = RST_CONT_ID_B;

    // parser state in the bench
    logic [63:0] pos_r      = 64'd0;
    logic [2:0]  ph         = PH_PRE;
    int          vint_left  = 0;
    logic [63:0] vint_acc   = 64'd0;
    logic [63:0] held_id    = 64'd0;
    logic [63:0] hdr_start  = 64'd0;
    logic [63:0] skip_left  = 64'd0;
    logic [63:0] stack_ends[MAX_DEPTH];
    int          depth_cnt  = 0;

    // headers still owed by the block, oldest first
    t_result     expected_headers[$];

    ebml_element_header_parser dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_data_byte     (in_byte),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_element_id    (out_id),
        .o_element_size  (out_size),
        .o_element_start (out_start),
        .o_payload_start (out_pay),
        .o_nesting_depth (out_depth),
        .o_is_container  (out_cont),
        .o_depth_overflow(out_over),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // 2 ns clock
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    // zero bits above the length marker, 8 when the byte is all zero
    function automatic int marker_pos(input logic [7:0] b);
        int n;
        n = 0;
        while (n < 8 && b[7 - n] == 1'b0) n++;
        return n;
    endfunction

    // first byte of a vint: the bits below the marker
    function automatic logic [63:0] head_bits(input logic [7:0] b, input int n);
        if (n >= 8) return 64'd0;
        return {56'd0, b & (8'h7f >> n)};
    endfunction

    // advance the model by one accepted byte, queueing any header it completes
    function automatic void parse_byte(input logic [7:0] b);
        logic [63:0] p;
        logic [63:0] pay;
        logic        hit;
        logic        over;
        logic        cont;
        int          n;
        t_result     hdr;
        p = pos_r;
        pos_r = p + 64'd1;
        if (ph == PH_PRE) begin
            // nothing happens below the start offset
            if (p < {32'd0, cfg_start}) return;
            ph = PH_HDR;
        end
        case (ph)
            PH_HDR: begin
                // close every container whose end has been reached or passed
                while (depth_cnt > 0 && p >= stack_ends[depth_cnt - 1]) depth_cnt--;
                if (depth_cnt == 0 && p >= {32'd0, cfg_top}) begin
                    ph = PH_DONE;
                end else begin
                    hdr_start = p;
                    n = marker_pos(b);
                    vint_acc = head_bits(b, n);
                    vint_left = n;
                    if (n == 0) begin
                        held_id = vint_acc;
                        ph = PH_SZ_FIRST;
                    end else begin
                        ph = PH_ID_MORE;
                    end
                end
            end
            PH_ID_MORE: begin
                vint_acc = {vint_acc[55:0], b};
                vint_left--;
                if (vint_left == 0) begin
                    held_id = vint_acc;
                    ph = PH_SZ_FIRST;
                end
            end
            PH_SZ_FIRST, PH_SZ_MORE: begin
                if (ph == PH_SZ_FIRST) begin
                    n = marker_pos(b);
                    vint_acc = head_bits(b, n);
                    vint_left = n;
                end else begin
                    vint_acc = {vint_acc[55:0], b};
                    vint_left--;
                end
                if (vint_left != 0) begin
                    ph = PH_SZ_MORE;
                end else begin
                    pay  = p + 64'd1;
                    hit  = (held_id == {36'd0, cfg_ida}) || (held_id == {36'd0, cfg_idb});
                    over = hit && (depth_cnt >= MAX_DEPTH);
                    cont = hit && !over;
                    hdr.element_id     = held_id;
                    hdr.element_size   = vint_acc;
                    hdr.element_start  = hdr_start;
                    hdr.payload_start  = pay;
                    hdr.nesting_depth  = 3'(depth_cnt);
                    hdr.is_container   = cont;
                    hdr.depth_overflow = over;
                    expected_headers.push_back(hdr);
                    if (cont) begin
                        // end offset wraps like the stream position
                        stack_ends[depth_cnt] = pay + vint_acc;
                        depth_cnt++;
                        ph = PH_HDR;
                    end else if (vint_acc == 64'd0) begin
                        ph = PH_HDR;
                    end else begin
                        skip_left = vint_acc;
                        ph = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                skip_left--;
                if (skip_left == 64'd0) ph = PH_HDR;
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stream building
    // ------------------------------------------------------------------

    // vint of len bytes, len 9 being a zero first byte and eight value bytes
    function automatic byte_q_t vint_encode(input logic [63:0] v, input int len);
        byte_q_t q;
        if (len >= 9) begin
            q.push_back(8'h00);
            for (int i = 7; i >= 0; i--) q.push_back(v[8*i +: 8]);
        end else begin
            q.push_back((8'h80 >> (len - 1)) | (v[8*(len-1) +: 8] & (8'h7f >> (len - 1))));
            for (int i = len - 2; i >= 0; i--) q.push_back(v[8*i +: 8]);
        end
        return q;
    endfunction

    // shortest vint holding v, sometimes padded out to a longer one
    function automatic int pick_len(input logic [63:0] v);
        int l;
        l = 9;
        for (int k = 8; k >= 1; k--) begin
            if (v < (64'd1 << (7 * k))) l = k;
        end
        if ($urandom_range(0, 3) == 0) l = $urandom_range(l, 9);
        return l;
    endfunction

    // one leaf with random id, small size and random payload
    function automatic byte_q_t make_leaf();
        byte_q_t     q;
        logic [63:0] id;
        logic [63:0] size;
        int          l;
        int          r;
        // a leaf must never carry a container id, else its payload is parsed
        do begin
            r = $urandom_range(0, 99);
            l = (r < 70) ? $urandom_range(1, 4) : (r < 88) ? $urandom_range(5, 8) : 9;
            id = {$urandom, $urandom};
            if (l < 9) id = id & ((64'd1 << (7 * l)) - 64'd1);
        end while (id == {36'd0, cfg_ida} || id == {36'd0, cfg_idb});
        size = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(9, 40);
        q = vint_encode(id, l);
        q = {q, vint_encode(size, pick_len(size))};
        repeat (int'(size)) q.push_back(8'($urandom));
        return q;
    endfunction

    function automatic byte_q_t make_leaves(input int n);
        byte_q_t q;
        repeat (n) q = {q, make_leaf()};
        return q;
    endfunction

    // a spine of nested containers built inside out, with leaves beside
    // each level; deep spines run past the stack and give overflow items
    function automatic byte_q_t make_nest();
        byte_q_t     inner;
        byte_q_t     hdr;
        logic [63:0] id;
        logic [63:0] size;
        int          levels;
        int          r;
        int          d;
        r = $urandom_range(0, 99);
        levels = (r < 40) ? 0 : (r < 80) ? $urandom_range(1, 3) : $urandom_range(4, 6);
        inner = make_leaves($urandom_range((levels == 0) ? 1 : 0, 2));
        for (int j = levels - 1; j >= 0; j--) begin
            id = ($urandom_range(0, 1) == 1) ? {36'd0, cfg_ida} : {36'd0, cfg_idb};
            size = inner.size();
            // outermost size off by a little: parent ends early or late
            if (j == 0 && $urandom_range(0, 99) < 15) begin
                d = $urandom_range(1, 3);
                if ($urandom_range(0, 1) == 1) size = size + d;
                else size = (size > d) ? size - d : 64'd0;
            end
            hdr = vint_encode(id, pick_len(id));
            hdr = {hdr, vint_encode(size, pick_len(size))};
            inner = {make_leaves($urandom_range(0, 1)), hdr, inner,
                     make_leaves($urandom_range(0, 1))};
        end
        return inner;
    endfunction

    // junk byte; a size first byte stays one byte long so skips stay short
    function automatic logic [7:0] noise_byte();
        if (ph == PH_SZ_FIRST) return 8'h80 | 8'($urandom_range(0, 127));
        return 8'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------

    // one byte item, with random idle cycles in front of it
    task automatic send_byte(input logic [7:0] b);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 17) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (!in_ready);
        parse_byte(b);
        bytes_sent++;
    endtask

    task automatic send_all(input byte_q_t q);
        foreach (q[i]) send_byte(q[i]);
    endtask

    // feed junk until the parser is back at a header boundary
    task automatic realign();
        while (ph != PH_HDR && ph != PH_DONE) send_byte(noise_byte());
    endtask

    // stop sending, let every owed header arrive and the pipe run dry
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_headers.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_START_OFFSET: cfg_start = data;
            CFG_TOP_END:      cfg_top   = data;
            CFG_CONT_ID_A:    cfg_ida   = data[27:0];
            CFG_CONT_ID_B:    cfg_idb   = data[27:0];
            default: begin
            end
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_config(input logic [31:0] start, input logic [31:0] top,
                                input logic [27:0] ida, input logic [27:0] idb);
        wait_idle();
        write_reg(CFG_START_OFFSET, start);
        write_reg(CFG_TOP_END, top);
        write_reg(CFG_CONT_ID_A, {4'd0, ida});
        write_reg(CFG_CONT_ID_B, {4'd0, idb});
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    // receiver stalls at random except during the steady stretch
    always @(negedge clk) begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 17);
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // every header item taken is matched against the oldest one owed
    always @(posedge clk) begin
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_headers.size() == 0) begin
                $display("%0t: header item not expected, expected none actual id %h",
                         $time, out_id);
                errors++;
            end else begin
                want = expected_headers.pop_front();
                check_field("element_id", want.element_id, out_id);
                check_field("element_size", want.element_size, out_size);
                check_field("element_start", want.element_start, out_start);
                check_field("payload_start", want.payload_start, out_pay);
                check_field("nesting_depth", {61'd0, want.nesting_depth}, {61'd0, out_depth});
                check_field("is_container", {63'd0, want.is_container}, {63'd0, out_cont});
                check_field("depth_overflow", {63'd0, want.depth_overflow}, {63'd0, out_over});
            end
        end
    end

    // give up when no channel has moved an item for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall <= 0;
        end else begin
            stall <= stall + 1;
        end
        if (stall >= WATCHDOG_LIMIT) begin
            $display("ebml_element_header_parser: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // start offset parked at the top, then dropped below the position:
    // the very next byte opens a header
    task automatic test_start_offset();
        write_reg(CFG_TOP_END, 32'hffff_ffff);
        write_reg(CFG_START_OFFSET, 32'hffff_ffff);
        repeat (3) send_byte(8'($urandom));
        wait_idle();
        write_reg(CFG_START_OFFSET, 32'd0);
    endtask

    // container ids at both extremes; a zero sized container is closed at
    // the next header and a zero sized leaf runs straight into the next one
    task automatic test_zero_sizes();
        byte_q_t q;
        write_reg(CFG_CONT_ID_A, 32'h0000_0000);
        write_reg(CFG_CONT_ID_B, 32'h0fff_ffff);
        q = {8'h80, 8'h80, 8'h81, 8'h80};
        send_all(q);
    endtask

    // all-ones size in a nine byte vint: the container end wraps below the
    // position and is popped by the following header
    task automatic test_wraparound();
        byte_q_t q;
        q = {8'h80, 8'h00};
        repeat (8) q.push_back(8'hff);
        q.push_back(8'h81);
        q.push_back(8'h81);
        q.push_back(8'h5a);
        send_all(q);
    endtask

    // one byte container holding a four byte child: no backtracking, the
    // parent goes at the next header
    task automatic test_overrun();
        byte_q_t q;
        q = {8'h80, 8'h81, 8'h82, 8'h82, 8'h55, 8'haa};
        send_all(q);
    endtask

    // well formed trees most of the time, plus junk and cut-off ids
    task automatic run_random(input int n_items);
        byte_q_t q;
        int      target;
        int      r;
        int      l;
        target = bytes_sent + n_items;
        while (bytes_sent < target) begin
            realign();
            r = $urandom_range(0, 99);
            if (r < 80) begin
                q = make_nest();
                send_all(q);
            end else if (r < 90) begin
                repeat ($urandom_range(1, 12)) send_byte(noise_byte());
            end else begin
                // id cut short, junk finishes it off
                l = $urandom_range(2, 9);
                q = vint_encode({$urandom, $urandom}, l);
                for (int i = 0; i < $urandom_range(1, l - 1); i++) send_byte(q[i]);
            end
        end
    endtask

    task automatic test_random_streams();
        apply_config($urandom, 32'hffff_ffff, RST_CONT_ID_A, RST_CONT_ID_B);
        run_random(PHASE_ITEMS);
        // long stretch with both sides always willing
        apply_config($urandom, $urandom_range(32'h1000_0000, 32'hffff_fffe),
                     28'h000_0000, 28'hfff_ffff);
        steady = 1'b1;
        run_random(PHASE_ITEMS);
        steady = 1'b0;
        apply_config($urandom, 32'hffff_ffff, 28'($urandom), 28'($urandom));
        run_random(PHASE_ITEMS);
    endtask

    // top_end just ahead of the position: a few short leaves, then the
    // parser stops and every further byte is dropped
    task automatic test_top_end();
        byte_q_t q;
        realign();
        apply_config(cfg_start, pos_r[31:0] + 32'd6, RST_CONT_ID_A, RST_CONT_ID_B);
        repeat (4) begin
            q.push_back(8'h81);
            q.push_back(8'h80);
        end
        repeat (6) q.push_back(8'($urandom));
        send_all(q);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_start_offset();
        test_zero_sizes();
        test_wraparound();
        test_overrun();
        test_random_streams();
        test_top_end();

        wait_idle();
        if (errors == 0) begin
            $display("ebml_element_header_parser: match");
        end else begin
            $display("ebml_element_header_parser: mismatch");
        end
        $finish;
    end

endmodule
